FILE: src/lzpwd_pkg.sv
package lzpwd_pkg;

  localparam int WIN_AW = 12;
  localparam int WIN_DEPTH = 4096;
  localparam int LEN_W = 24;
  localparam logic [WIN_AW-1:0] START_POS = 12'hFEE;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_FLAG  = 3'b001,
    PH_TOKEN = 3'b010,
    PH_HIGH  = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_COPY = 2'b10
  } state_t;

endpackage

FILE: src/lzpwd_ram.sv
module lzpwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/lzpwd_preset.sv
module lzpwd_preset
  import lzpwd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [WIN_AW-1:0] addr,
  output logic [7:0]        data
);

  localparam logic [WIN_AW-1:0] RUN_END = 12'hD00;
  localparam logic [WIN_AW-1:0] ZERO_END = 12'hF80;
  localparam logic [12:0] RECIP_13 = 13'd5042;

  logic [24:0] prod;
  logic [7:0]  value;

  // floor(addr / 13) for addr below 0xD00
  assign prod = 25'(addr) * 25'(RECIP_13);

  always_comb begin
    priority if (addr < RUN_END) begin
      value = prod[23:16];
    end else if (addr[11:8] == 4'hD) begin
      value = addr[7:0];
    end else if (addr[11:8] == 4'hE) begin
      value = ~addr[7:0];
    end else if (addr < ZERO_END) begin
      value = 8'h00;
    end else if (addr < START_POS) begin
      value = 8'h20;
    end else begin
      value = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= value;
    end
  end

endmodule

FILE: src/lzss_preset_window_decoder.sv
// channel | dir | handshake          | beat
// in      | in  | in_valid/in_stall  | in_item_t: compressed byte, new_stream
// out     | out | out_valid/out_stall| out_item_t: byte, last_of_run, stream_done
// cfg     | in  | cfg_wr_en          | output_length
// Flag, literal and match low bytes are each taken in one beat; a match high
// byte starts a copy of up to 18 bytes, one window read and write per byte.
// The window RAM gets no clearing pass: entries not written since the stream
// started read the preset pattern, generated from the address.
// Reset is synchronous; a stall on out holds the copy and the input.
module lzss_preset_window_decoder
  import lzpwd_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  state_t                  state, state_next;
  phase_t                  phase, phase_next;
  logic [7:0]              flag_bits, flag_bits_next;
  logic [2:0]              flag_pos, flag_pos_next;
  logic [7:0]              match_low, match_low_next;
  logic [WIN_AW-1:0]       wp, wp_next;
  logic [WIN_AW:0]         written, written_next;
  logic [COUNT_BITS-1:0]   count, count_next;
  logic [LEN_W-1:0]        length;
  logic [4:0]              remaining, remaining_next;
  logic [WIN_AW-1:0]       src, src_next;
  logic                    fwd_hit, fwd_hit_next;
  logic [7:0]              fwd_byte, fwd_byte_next;
  logic                    sel_ram, sel_ram_next;
  logic                    out_valid_next;
  out_item_t               out_data_next;

  logic                    out_free;
  logic                    acc;
  logic                    restart;
  logic [COUNT_BITS-1:0]   base_count;
  logic [WIN_AW-1:0]       base_wp;
  logic [WIN_AW:0]         base_written;
  phase_t                  base_phase;
  logic                    done_eff;
  logic [CMP_W-1:0]        left;
  logic [4:0]              len_raw;
  logic [WIN_AW-1:0]       src_calc;
  logic [WIN_AW-1:0]       src_inc;
  logic                    emit;
  logic [7:0]              emit_byte;
  logic [COUNT_BITS-1:0]   count_inc;
  logic                    emit_done;
  logic [7:0]              copy_byte;

  logic                    ram_we;
  logic                    ram_re;
  logic [WIN_AW-1:0]       ram_raddr;
  logic [7:0]              ram_q;
  logic [7:0]              preset_q;

  function automatic logic in_range(input logic [WIN_AW-1:0] a,
                                    input logic [WIN_AW:0] wr);
    logic [WIN_AW-1:0] off;
    off = a - START_POS;
    return {1'b0, off} < wr;
  endfunction

  lzpwd_ram #(
    .WIDTH(8),
    .DEPTH(WIN_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(base_wp),
    .wdata(emit_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  lzpwd_preset u_preset (
    .clk (clk),
    .en  (ram_re),
    .addr(ram_raddr),
    .data(preset_q)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign acc = in_valid && !in_stall;
  assign restart = acc && in_data.new_stream;

  assign base_count = restart ? '0 : count;
  assign base_wp = restart ? START_POS : wp;
  assign base_written = restart ? '0 : written;
  assign base_phase = restart ? PH_FLAG : phase;
  assign done_eff = CMP_W'(base_count) >= CMP_W'(length);
  assign left = CMP_W'(length) - CMP_W'(base_count);
  assign len_raw = 5'(in_data.in_byte[3:0]) + 5'd3;
  assign src_calc = {in_data.in_byte[7:4], match_low};
  assign src_inc = src + 1'b1;
  assign count_inc = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
  assign emit_done = CMP_W'(count_inc) >= CMP_W'(length);
  assign copy_byte = fwd_hit ? fwd_byte : (sel_ram ? ram_q : preset_q);
  assign emit_byte = (state == ST_COPY) ? copy_byte : in_data.in_byte;
  assign ram_we = emit;

  always_comb begin
    state_next = state;
    phase_next = phase;
    flag_bits_next = flag_bits;
    flag_pos_next = flag_pos;
    match_low_next = match_low;
    wp_next = wp;
    written_next = written;
    count_next = count;
    remaining_next = remaining;
    src_next = src;
    fwd_hit_next = fwd_hit;
    fwd_byte_next = fwd_byte;
    sel_ram_next = sel_ram;
    out_valid_next = out_valid && out_stall;
    out_data_next = out_data;
    emit = 1'b0;
    ram_re = 1'b0;
    ram_raddr = src_calc;

    if (restart) begin
      phase_next = PH_FLAG;
      flag_bits_next = '0;
      flag_pos_next = '0;
      match_low_next = '0;
      wp_next = START_POS;
      written_next = '0;
      count_next = '0;
    end

    unique case (state)
      ST_IDLE: begin
        if (acc && !done_eff) begin
          unique case (base_phase)
            PH_FLAG: begin
              flag_bits_next = in_data.in_byte;
              flag_pos_next = '0;
              phase_next = PH_TOKEN;
            end
            PH_TOKEN: begin
              if (flag_bits[flag_pos]) begin
                emit = 1'b1;
                out_data_next.last_of_run = 1'b1;
                phase_next = (flag_pos == 3'd7) ? PH_FLAG : PH_TOKEN;
                flag_pos_next = flag_pos + 1'b1;
              end else begin
                match_low_next = in_data.in_byte;
                phase_next = PH_HIGH;
              end
            end
            PH_HIGH: begin
              ram_re = 1'b1;
              src_next = src_calc;
              remaining_next = (CMP_W'(len_raw) > left) ? left[4:0] : len_raw;
              fwd_hit_next = 1'b0;
              sel_ram_next = in_range(src_calc, written);
              state_next = ST_COPY;
            end
            default: begin
              phase_next = PH_FLAG;
            end
          endcase
        end
      end
      ST_COPY: begin
        if (out_free) begin
          emit = 1'b1;
          remaining_next = remaining - 1'b1;
          out_data_next.last_of_run = (remaining == 5'd1);
          if (remaining == 5'd1) begin
            state_next = ST_IDLE;
            phase_next = (flag_pos == 3'd7) ? PH_FLAG : PH_TOKEN;
            flag_pos_next = flag_pos + 1'b1;
          end else begin
            ram_re = 1'b1;
            ram_raddr = src_inc;
            src_next = src_inc;
            fwd_hit_next = (src_inc == wp);
            fwd_byte_next = copy_byte;
            sel_ram_next = in_range(src_inc, written);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (emit) begin
      wp_next = base_wp + 1'b1;
      written_next = base_written[WIN_AW] ? base_written : base_written + 1'b1;
      count_next = count_inc;
      out_valid_next = 1'b1;
      out_data_next.out_byte = emit_byte;
      out_data_next.stream_done = emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_FLAG;
      flag_bits <= '0;
      flag_pos <= '0;
      match_low <= '0;
      wp <= START_POS;
      written <= '0;
      count <= '0;
      length <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      flag_bits <= flag_bits_next;
      flag_pos <= flag_pos_next;
      match_low <= match_low_next;
      wp <= wp_next;
      written <= written_next;
      count <= count_next;
      remaining <= remaining_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        length <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    src <= src_next;
    fwd_hit <= fwd_hit_next;
    fwd_byte <= fwd_byte_next;
    sel_ram <= sel_ram_next;
    out_data <= out_data_next;
  end

endmodule

FILE: test/lzss_preset_window_decoder_checker.sv
`timescale 1ns / 100ps
module lzss_preset_window_decoder_checker
  import lzpwd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  output int               pending,
  output int               mismatches
);

  localparam logic [LEN_W-1:0] COUNT_MAX = '1;

  logic [7:0]        win [WIN_DEPTH];
  logic [WIN_AW-1:0] wr_pos;
  logic [7:0]        flags;
  int                flag_idx;
  logic [7:0]        low_byte;
  phase_t            phase;
  logic [LEN_W-1:0]  produced;
  logic [LEN_W-1:0]  out_len;
  out_item_t         pending_bytes[$];

  function automatic logic [7:0] preset_byte(int a);
    if (a < 'hD00) return 8'(a / 13);
    if (a < 'hE00) return a[7:0];
    if (a < 'hF00) return 8'hFF - a[7:0];
    if (a < 'hF80) return 8'h00;
    if (a < 'hFEE) return 8'h20;
    return 8'h00;
  endfunction

  function automatic void restart_stream();
    for (int a = 0; a < WIN_DEPTH; a++) win[a] = preset_byte(a);
    wr_pos = START_POS;
    flags = '0;
    flag_idx = 0;
    low_byte = '0;
    phase = PH_FLAG;
    produced = '0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    out_item_t beat;
    win[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
    if (produced != COUNT_MAX) produced = produced + 1'b1;
    beat.out_byte = b;
    beat.last_of_run = 1'b0;
    beat.stream_done = (produced >= out_len);
    pending_bytes.push_back(beat);
  endfunction

  function automatic void advance_token();
    flag_idx++;
    if (flag_idx >= 8) begin
      flag_idx = 0;
      phase = PH_FLAG;
    end else begin
      phase = PH_TOKEN;
    end
  endfunction

  function automatic void decode_beat(in_item_t beat);
    logic [WIN_AW-1:0] src;
    logic [LEN_W-1:0]  room;
    int                run;
    int                n;
    out_item_t         tail;
    n = 0;
    if (beat.new_stream) restart_stream();
    if (produced >= out_len) return;
    case (phase)
      PH_FLAG: begin
        flags = beat.in_byte;
        flag_idx = 0;
        phase = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (flags[flag_idx]) begin
          emit_byte(beat.in_byte);
          n = 1;
          advance_token();
        end else begin
          low_byte = beat.in_byte;
          phase = PH_HIGH;
        end
      end
      default: begin
        src = {beat.in_byte[7:4], low_byte};
        run = int'(beat.in_byte[3:0]) + 3;
        room = out_len - produced;
        if (run > room) run = int'(room);
        for (int k = 0; k < run; k++) begin
          emit_byte(win[src]);
          src = src + 1'b1;
          n++;
        end
        advance_token();
      end
    endcase
    if (n > 0) begin
      tail = pending_bytes.pop_back();
      tail.last_of_run = 1'b1;
      pending_bytes.push_back(tail);
    end
  endfunction

  function automatic void check_beat(out_item_t got);
    out_item_t want;
    if (pending_bytes.size() == 0) begin
      $error("unexpected output beat: out_byte %02h", got.out_byte);
      mismatches++;
      return;
    end
    want = pending_bytes.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
      mismatches++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
      mismatches++;
    end
    if (got.stream_done !== want.stream_done) begin
      $error("stream_done: expected %0b, got %0b", want.stream_done, got.stream_done);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_stream();
      out_len = '0;
      pending_bytes.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) out_len = cfg_wr_data;
      if (in_valid && !in_stall) decode_beat(in_data);
      if (out_valid && !out_stall) check_beat(out_data);
    end
    pending = pending_bytes.size();
  end

endmodule

FILE: test/lzss_preset_window_decoder_tb.sv
`timescale 1ns / 100ps
module lzss_preset_window_decoder_tb
  import lzpwd_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_BEATS = 46;
  localparam int NUM_PHASES = 6;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;
  int               pending;
  int               mismatches;
  int               cycles = 0;
  bit               quiet = 1'b0;

  lzss_preset_window_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lzss_preset_window_decoder_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (!quiet && $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic ns);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= in_item_t'{in_byte: b, new_stream: ns};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_stream(input int tokens, inout int sent);
    logic [WIN_AW-1:0] pos;
    logic [WIN_AW-1:0] src;
    logic [7:0]        flag;
    logic [3:0]        nib;
    pos = START_POS;
    flag = '0;
    for (int t = 0; t < tokens; t++) begin
      if (t % 8 == 0) begin
        flag = 8'($urandom);
        send_beat(flag, t == 0);
        sent++;
      end
      if ($urandom_range(0, 15) == 0) begin
        send_beat(8'($urandom), 1'($urandom));
        sent++;
      end
      if (flag[t % 8]) begin
        send_beat(8'($urandom), 1'b0);
        pos = pos + 1'b1;
        sent++;
      end else begin
        nib = 4'($urandom);
        if ($urandom_range(0, 2) == 0) src = pos - WIN_AW'($urandom_range(1, 20));
        else src = WIN_AW'($urandom);
        send_beat(src[7:0], 1'b0);
        send_beat({src[11:8], nib}, 1'b0);
        pos = WIN_AW'(pos + nib + 3);
        sent += 2;
      end
    end
  endtask

  initial begin
    logic [LEN_W-1:0] len;
    int               sent;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_length(24'd0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);

    set_length(24'hFFFFFF);
    send_beat(8'h05, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hED, 1'b0);
    send_beat(8'hF0, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h0F, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hD5, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hE2, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hF7, 1'b0);

    set_length(24'd20);
    send_beat(8'h00, 1'b1);
    send_beat(8'h10, 1'b0);
    send_beat(8'h0F, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h0F, 1'b0);
    send_beat(8'h55, 1'b0);

    set_length(24'd5);
    send_beat(8'hA5, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: len = 24'hFFFFFF;
        2: len = 24'd1;
        4: len = 24'h000200;
        default: len = LEN_W'($urandom_range(40, 400));
      endcase
      set_length(len);
      quiet = (p == NUM_PHASES - 1);
      while (sent < (p + 1) * PHASE_BEATS) begin
        if (len < 40) send_stream($urandom_range(1, 2), sent);
        else send_stream($urandom_range(3, 24), sent);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/lzpwd_pkg.sv
src/lzpwd_ram.sv
src/lzpwd_preset.sv
src/lzss_preset_window_decoder.sv
test/lzss_preset_window_decoder_checker.sv
test/lzss_preset_window_decoder_tb.sv
